// ===== design/hilbert_iq_converter_top_assert.svh =====
// ----------------------------------------------------------------------------
// hilbert_iq_converter_top assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HILBERT_IQ_CONVERTER_TOP_ASSERT_SVH
`define HILBERT_IQ_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HIC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hic: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hic: next-cycle check failed");

`endif

// ===== design/hic_pkg.sv =====
// ----------------------------------------------------------------------------
// hic_pkg
// Shared types, widths and the Hilbert coefficient builder.
// ----------------------------------------------------------------------------
package hic_pkg;

  localparam int SAMPLE_W    = 16;  // sample / result field width
  localparam int COEF_W      = 18;  // signed Q.16 coefficient width
  localparam int COEF_FRAC   = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam longint ONE_Q30              = 64'sd1073741824;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam int SERIES_TERMS             = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } hic_state_t;

  // sequencer -> datapath controls
  typedef struct packed {
    logic clear;  // zero the accumulator for a new request
    logic issue;  // a ring read for one tap goes out this cycle
  } hic_ctrl_t;

  // Shift-subtract divide, used only while building constants.
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint cos_series(longint unsigned a);
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    a2   = (a * a) >> 30;
    term = longint'(ONE_Q30);
    sum  = ONE_Q30;
    for (longint unsigned k = 1; k <= SERIES_TERMS; k++) begin
      term = udiv((term * a2) >> 30, (2 * k - 1) * (2 * k));
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return sum;
  endfunction

  function automatic longint sin_series(longint unsigned a);
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    for (longint unsigned k = 1; k <= SERIES_TERMS; k++) begin
      term = udiv((term * a2) >> 30, (2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return sum;
  endfunction

  // cos(2*pi*i/span) in Q30
  function automatic longint window_cos(longint unsigned i, longint unsigned span);
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned a;
    longint          res;
    quad = udiv(4 * i, span);
    rem  = 4 * i - quad * span;
    a    = udiv(PI_HALF_Q30 * rem, span);
    unique case (quad[1:0])
      2'd0:    res = cos_series(a);
      2'd1:    res = -sin_series(a);
      2'd2:    res = -cos_series(a);
      default: res = sin_series(a);
    endcase
    return res;
  endfunction

  // Hamming-windowed Hilbert tap k (k = 0 is the newest sample), Q.16.
  function automatic longint coef_value(int k, int taps);
    longint          center;
    longint          n;
    longint unsigned mag;
    longint          w;
    longint unsigned num;
    longint unsigned den;
    longint          c;
    center = longint'(taps - 1) >>> 1;
    n      = longint'(k) - center;
    mag    = (n < 0) ? longint'(-n) : longint'(n);
    if (mag[0] == 1'b0) return 64'sd0;
    w   = (54 * ONE_Q30 - 46 * window_cos(longint'(k), longint'(taps - 1))) / 100;
    num = longint'(w) << 17;
    den = PI_Q30 * mag;
    c   = longint'(udiv(num + (den >> 1), den));
    return (n < 0) ? -c : c;
  endfunction

endpackage

// ===== design/hic_ring_ram.sv =====
// ----------------------------------------------------------------------------
// hic_ring_ram
// Sample ring: one write port, one registered read port, per-entry valid
// bits so that an unwritten entry reads as zero after reset.
// ----------------------------------------------------------------------------
module hic_ring_ram #(
  parameter int DEPTH = 127,
  parameter int AW    = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [hic_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  output logic signed [hic_pkg::SAMPLE_W-1:0] rd_data
);

  logic signed [hic_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]                    valid_r;
  logic signed [hic_pkg::SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/hic_seq.sv =====
// ----------------------------------------------------------------------------
// hic_seq
// Per-request sequencer: writes the new sample, walks the ring from newest
// to oldest one tap per cycle, waits for the MAC to drain, hands off.
// ----------------------------------------------------------------------------
module hic_seq #(
  parameter int TAPS = 127,
  parameter int AW   = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mac_busy,
  input  logic               out_free,
  output logic               out_load,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr,
  output logic [AW-1:0]      rd_tap,
  output hic_pkg::hic_ctrl_t ctrl
);

  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  hic_pkg::hic_state_t state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] tap_r, tap_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hic_pkg::ST_IDLE;
      pos_r   <= '0;
      tap_r   <= '0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      tap_r   <= tap_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    tap_nxt   = tap_r;
    addr_nxt  = addr_r;
    ctrl      = '0;
    wr_en     = 1'b0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      hic_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_en      = 1'b1;
          ctrl.clear = 1'b1;
          addr_nxt   = pos_r;
          tap_nxt    = '0;
          pos_nxt    = (pos_r == LAST) ? '0 : pos_r + AW'(1);
          state_nxt  = hic_pkg::ST_RUN;
        end
      end
      hic_pkg::ST_RUN: begin
        ctrl.issue = 1'b1;
        addr_nxt   = (addr_r == '0) ? LAST : addr_r - AW'(1);
        tap_nxt    = tap_r + AW'(1);
        if (tap_r == LAST) begin
          state_nxt = hic_pkg::ST_DRAIN;
        end
      end
      hic_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = hic_pkg::ST_FINISH;
        end
      end
      hic_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = hic_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hic_pkg::ST_IDLE;
    endcase
  end

  assign wr_addr = pos_r;
  assign rd_addr = addr_r;
  assign rd_tap  = tap_r;

endmodule

// ===== design/hic_mac.sv =====
// ----------------------------------------------------------------------------
// hic_mac
// Coefficient table, registered multiply, accumulate, delay tap capture,
// round half up and saturate.
// ----------------------------------------------------------------------------
module hic_mac #(
  parameter int TAPS  = 127,
  parameter int DELAY = 63,
  parameter int AW    = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hic_pkg::hic_ctrl_t                  ctrl,
  input  logic [AW-1:0]                       rd_tap,
  input  logic signed [hic_pkg::SAMPLE_W-1:0] rd_data,
  output logic                                busy,
  output logic signed [hic_pkg::SAMPLE_W-1:0] in_phase,
  output logic signed [hic_pkg::SAMPLE_W-1:0] quadrature
);

  localparam int SW     = hic_pkg::SAMPLE_W;
  localparam int PROD_W = SW + hic_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + AW;
  localparam int Q_W    = ACC_W - hic_pkg::COEF_FRAC;
  localparam int DELAY_MOD = DELAY % TAPS;

  logic signed [hic_pkg::COEF_W-1:0] coef_tbl [TAPS];

  for (genvar g = 0; g < TAPS; g++) begin : g_coef
    localparam longint C = hic_pkg::coef_value(g, TAPS);
    assign coef_tbl[g] = C[hic_pkg::COEF_W-1:0];
  end

  logic                     rd_vld_r;
  logic [AW-1:0]            rd_tap_r;
  logic                     prod_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [SW-1:0]     ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= ctrl.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      rd_tap_r <= rd_tap;
    end
    if (rd_vld_r) begin
      prod_r <= rd_data * coef_tbl[rd_tap_r];
      if (rd_tap_r == AW'(DELAY_MOD)) begin
        ip_r <= rd_data;
      end
    end
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // round half up: add one half LSB of the result, drop the fraction
  logic signed [ACC_W-1:0] biased;
  logic        [Q_W-1:0]   q_full;
  logic                    q_pos_ovf;
  logic                    q_neg_ovf;

  always_comb begin
    biased    = acc_r + {{(ACC_W - hic_pkg::COEF_FRAC){1'b0}}, 1'b1,
                         {(hic_pkg::COEF_FRAC - 1){1'b0}}};
    q_full    = biased[ACC_W-1:hic_pkg::COEF_FRAC];
    q_pos_ovf = !q_full[Q_W-1] && (|q_full[Q_W-2:SW-1]);
    q_neg_ovf = q_full[Q_W-1] && !(&q_full[Q_W-2:SW-1]);
    priority if (q_pos_ovf) begin
      quadrature = {1'b0, {(SW - 1){1'b1}}};
    end else if (q_neg_ovf) begin
      quadrature = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      quadrature = q_full[SW-1:0];
    end
  end

  assign busy     = rd_vld_r | prod_vld_r;
  assign in_phase = ip_r;

endmodule

// ===== design/hilbert_iq_converter_top.sv =====
// A result is offered once its request has walked the ring and the MAC has
// drained. A new request is taken only after the last one is handed off; the
// sample ring's single read port, one tap per cycle, sets the pace.
// A finished result waits in the output register while the next request runs.
// Reset (rst_n low, synchronous) empties the output, rewinds the ring
// position and makes every ring entry read as zero; no clearing pass.
// ----------------------------------------------------------------------------
// hilbert_iq_converter_top
// Real-to-I/Q converter: I is the sample delayed by DELAY requests, Q is a
// TAPS-long Hamming-windowed FIR Hilbert transform of the sample stream.
// ----------------------------------------------------------------------------
module hilbert_iq_converter_top #(
  parameter int TAPS  = 127,  // FIR length, 3..255
  parameter int DELAY = 63    // in-phase delay, taken modulo TAPS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hic_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] sample
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hic_pkg::OUT_TDATA_W-1:0]    out_tdata   // [15:0] in_phase,
                                                         // [31:16] quadrature
);

  localparam int AW = $clog2(TAPS);
  localparam int SW = hic_pkg::SAMPLE_W;

  // sequencer <-> ring / MAC
  hic_pkg::hic_ctrl_t ctrl;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      rd_tap;
  logic               mac_busy;
  logic               out_load;
  logic               out_free;

  logic signed [SW-1:0] rd_data;
  logic signed [SW-1:0] in_phase;
  logic signed [SW-1:0] quadrature;

  // output register: holds one result so the next request can start
  logic                               out_tvalid_r;
  logic [hic_pkg::OUT_TDATA_W-1:0]    out_tdata_r;

  assign out_free = !out_tvalid_r || out_tready;

  hic_seq #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .mac_busy (mac_busy),
    .out_free (out_free),
    .out_load (out_load),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .rd_tap   (rd_tap),
    .ctrl     (ctrl)
  );

  // The ring holds the FIR history and doubles as the I delay line.
  hic_ring_ram #(
    .DEPTH (TAPS),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[SW-1:0]),
    .rd_en   (ctrl.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read -> multiply -> accumulate, two register stages behind the ring.
  hic_mac #(
    .TAPS  (TAPS),
    .DELAY (DELAY),
    .AW    (AW)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .rd_tap     (rd_tap),
    .rd_data    (rd_data),
    .busy       (mac_busy),
    .in_phase   (in_phase),
    .quadrature (quadrature)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {quadrature, in_phase};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/hic_checker.sv =====
// ----------------------------------------------------------------------------
// hic_checker
// Port-level checks for hilbert_iq_converter_top, attached by bind.
// ----------------------------------------------------------------------------
`include "hilbert_iq_converter_top_assert.svh"

module hic_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hic_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds its value
  `HIC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one request at a time: the input closes right after an accept
  `HIC_ASSERT_NEXT(a_in_closes, in_tvalid && in_tready, !in_tready)

  // a new result coincides with the input reopening
  `HIC_ASSERT_SAME(a_result_reopens, $rose(out_tvalid), in_tready)

endmodule

bind hilbert_iq_converter_top hic_checker u_hic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
